// ===== src/scdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdf_pkg
// Shared types, codes and constants of the scan code dedupe filter.
// ----------------------------------------------------------------------------
package scdf_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 20;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;

    localparam int DEF_HISTORY_DEPTH = 20;
    localparam int DEF_LINE_LIMIT    = 20;
    localparam int DEF_CODE_DIGITS   = 6;

    localparam logic [BYTE_W-1:0] TERM_RESET = 8'd13;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        RES_ACCEPT = 2'd0,
        RES_LENGTH = 2'd1,
        RES_DIGIT  = 2'd2,
        RES_DUP    = 2'd3
    } res_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_DECIDE,
        S_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic byte_step;   // take a non-terminator byte into the line
        logic term_take;   // terminator taken: stage early result, arm search
        logic search_step; // read one history entry
        logic decide;      // settle duplicate or accept, write history
        logic emit;        // load the output register and restart the line
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_term;      // incoming byte matches the terminator
        logic quick_reject; // line fails length or digit check
        logic last_addr;    // search address is at the last entry
    } dp_sts_t;

endpackage

// ===== src/scdf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdf_datapath
// Line collector, history memory with search compare, result and output regs.
// ----------------------------------------------------------------------------
module scdf_datapath
    import scdf_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int LINE_LIMIT    = DEF_LINE_LIMIT,
    parameter int CODE_DIGITS   = DEF_CODE_DIGITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [BYTE_W-1:0]   cfg_wr_data,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    output logic [VALUE_W-1:0]  code_value,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_written
);

    localparam int CNT_MAX = (LINE_LIMIT > CODE_DIGITS) ? LINE_LIMIT : CODE_DIGITS;
    localparam int CW      = $clog2(CNT_MAX + 1);
    localparam int AW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic [BYTE_W-1:0]   term_reg;

    logic [CW-1:0]       cc_reg, cc_next;
    logic                zs_reg, zs_next;
    logic [CW-1:0]       fz_reg, fz_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                ok_reg, ok_next;

    logic                restart;
    logic [CW-1:0]       base_cc;
    logic                base_zs;
    logic [CW-1:0]       base_fz;
    logic [VALUE_W-1:0]  base_acc;
    logic                base_ok;
    logic                is_digit;
    logic [CW-1:0]       line_len;
    logic                len_bad;

    logic [VALUE_W-1:0]  hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hv_reg;
    logic [AW-1:0]       wp_reg;
    logic [AW-1:0]       addr_reg;
    logic [VALUE_W-1:0]  rd_raw_reg;
    logic                rd_vld_reg;
    logic                cmp_vld_reg;
    logic                match_reg;
    logic [VALUE_W-1:0]  entry;
    logic                hit;

    logic [STATUS_W-1:0] res_status_reg;
    logic [VALUE_W-1:0]  res_code_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [VALUE_W-1:0]  out_code_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= TERM_RESET;
        end else if (cfg_wr_en) begin
            term_reg <= cfg_wr_data;
        end
    end

    // A byte arriving on a full line restarts it and becomes position zero.
    always_comb begin
        restart  = (cc_reg >= CW'(LINE_LIMIT));
        base_cc  = restart ? '0 : cc_reg;
        base_zs  = restart ? 1'b0 : zs_reg;
        base_fz  = restart ? '0 : fz_reg;
        base_acc = restart ? '0 : acc_reg;
        base_ok  = restart ? 1'b1 : ok_reg;
        is_digit = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);

        zs_next  = base_zs;
        fz_next  = base_fz;
        acc_next = base_acc;
        ok_next  = base_ok;
        if ((rx_byte == '0) && !base_zs) begin
            zs_next = 1'b1;
            fz_next = base_cc;
        end
        if (base_cc < CW'(CODE_DIGITS)) begin
            if (is_digit) begin
                acc_next = (base_acc << 3) + (base_acc << 1)
                         + VALUE_W'(rx_byte - ASCII_ZERO);
            end else begin
                ok_next = 1'b0;
            end
        end
        cc_next = base_cc + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit) begin
            cc_reg  <= '0;
            zs_reg  <= 1'b0;
            fz_reg  <= '0;
            acc_reg <= '0;
            ok_reg  <= 1'b1;
        end else if (cmd.byte_step) begin
            cc_reg  <= cc_next;
            zs_reg  <= zs_next;
            fz_reg  <= fz_next;
            acc_reg <= acc_next;
            ok_reg  <= ok_next;
        end
    end

    assign line_len = zs_reg ? fz_reg : cc_reg;
    assign len_bad  = (line_len != CW'(CODE_DIGITS));

    // History store. Entries never written read as zero through the valid bits.
    always_ff @(posedge aclk) begin
        if (cmd.decide && !hit && !match_reg) begin
            hist_mem[wp_reg] <= acc_reg;
        end
        rd_raw_reg <= hist_mem[addr_reg];
    end

    assign entry = rd_vld_reg ? rd_raw_reg : '0;
    assign hit   = cmp_vld_reg && (entry == acc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg      <= '0;
            wp_reg      <= '0;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            cmp_vld_reg <= 1'b0;
            match_reg   <= 1'b0;
        end else begin
            cmp_vld_reg <= cmd.search_step;
            rd_vld_reg  <= hv_reg[addr_reg];
            if (cmd.term_take) begin
                addr_reg  <= '0;
                match_reg <= 1'b0;
            end else begin
                if (cmd.search_step) begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (hit) begin
                    match_reg <= 1'b1;
                end
            end
            if (cmd.decide && !match_reg) begin
                hv_reg[wp_reg] <= 1'b1;
                wp_reg <= (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.term_take) begin
            res_status_reg <= len_bad ? RES_LENGTH : RES_DIGIT;
            res_code_reg   <= '0;
            res_slot_reg   <= '0;
        end else if (cmd.decide) begin
            res_code_reg <= acc_reg;
            if (match_reg) begin
                res_status_reg <= RES_DUP;
                res_slot_reg   <= '0;
            end else begin
                res_status_reg <= RES_ACCEPT;
                res_slot_reg   <= SLOT_W'(wp_reg);
            end
        end
        if (cmd.emit) begin
            out_code_reg   <= res_code_reg;
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    assign sts.is_term      = (rx_byte == term_reg);
    assign sts.quick_reject = len_bad || !ok_reg;
    assign sts.last_addr    = (addr_reg == AW'(HISTORY_DEPTH - 1));

    assign code_value   = out_code_reg;
    assign status       = out_status_reg;
    assign slot_written = out_slot_reg;

endmodule

// ===== src/scdf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdf_ctrl
// Sequencer for line intake, history search and result hand-off.
// ----------------------------------------------------------------------------
module scdf_ctrl
    import scdf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (sts.is_term) begin
                        cmd.term_take = 1'b1;
                        state_next = sts.quick_reject ? S_EMIT : S_SEARCH;
                    end else begin
                        cmd.byte_step = 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                cmd.search_step = 1'b1;
                if (sts.last_addr) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The compare of the last entry settles during this cycle.
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/scan_code_dedupe_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_code_dedupe_filter
// Collects scanner bytes into lines and reports each terminated line as an
// accepted new code, a wrong-length line, a non-digit line or a duplicate.
// ----------------------------------------------------------------------------
//   Channel  Direction  Ports                                       Handshake
//   s_       in         s_rx_byte                                   s_valid / s_ready
//   m_       out        m_code_value, m_status, m_slot_written      m_valid / m_ready
//   cfg_     in         cfg_wr_data (terminator byte)               cfg_wr_en
//
// Non-terminator beats are taken back to back while idle. A terminator that
// fails the length or digit check has its result staged on acceptance; one
// that passes walks the history memory one entry per cycle through its single
// read port, then the drain and decide states register its result.
// Reset clears the history through per-entry valid bits at once; no sweep.
// A stalled result holds in the output register; the next line's bytes are
// taken meanwhile, and a further terminator is taken but its result waits.
// ----------------------------------------------------------------------------
module scan_code_dedupe_filter
    import scdf_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int LINE_LIMIT    = DEF_LINE_LIMIT,
    parameter int CODE_DIGITS   = DEF_CODE_DIGITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [BYTE_W-1:0]   cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VALUE_W-1:0]  m_code_value,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot_written
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    scdf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    scdf_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .LINE_LIMIT    (LINE_LIMIT),
        .CODE_DIGITS   (CODE_DIGITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .rx_byte      (s_rx_byte),
        .cmd          (cmd),
        .sts          (sts),
        .code_value   (m_code_value),
        .status       (m_status),
        .slot_written (m_slot_written)
    );

endmodule

// ===== dv/scan_code_dedupe_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_code_dedupe_filter_tb
// Streams scanner bytes into the filter and checks every line verdict against
// a cycle-free model of the line collector and the code history ring. A short
// directed sequence covers the edge cases; random lines then run under several
// terminator settings, with idle gaps on both channels in some phases and none in others.
// ----------------------------------------------------------------------------
module scan_code_dedupe_filter_tb;
    import scdf_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = DEF_HISTORY_DEPTH + 16;
    localparam int PHASE_BYTES  = 115;
    localparam int POOL_SIZE    = 40;

    typedef struct {
        logic [VALUE_W-1:0] value;
        res_code_t          status;
        logic [SLOT_W-1:0]  slot;
    } line_verdict_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [BYTE_W-1:0]   cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_rx_byte = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [VALUE_W-1:0]  m_code_value;
    logic [STATUS_W-1:0] m_status;
    logic [SLOT_W-1:0]   m_slot_written;

    // Model state of the line collector and the history ring.
    logic [VALUE_W-1:0] seen_codes [DEF_HISTORY_DEPTH];
    int unsigned        ring_ptr;
    int unsigned        line_chars;
    int unsigned        zero_pos;
    bit                 zero_hit;
    int unsigned        code_acc;
    bit                 all_digits;
    logic [BYTE_W-1:0]  term_byte;

    logic [BYTE_W-1:0]  scan_byte_q [$];
    line_verdict_t      verdict_q [$];
    int unsigned        code_pool [POOL_SIZE];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int bytes_planned;
    int cycle_count;
    int status_seen [4];

    scan_code_dedupe_filter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_value   (m_code_value),
        .m_status       (m_status),
        .m_slot_written (m_slot_written)
    );

    always #5 aclk = ~aclk;

    function automatic void restart_line();
        line_chars = 0;
        zero_hit   = 1'b0;
        zero_pos   = 0;
        code_acc   = 0;
        all_digits = 1'b1;
    endfunction

    // Updates the line state for one accepted byte and queues the verdict
    // that a terminator produces.
    function automatic void take_scan_byte(input logic [BYTE_W-1:0] b);
        line_verdict_t      v;
        int unsigned        span;
        logic [VALUE_W-1:0] code;
        bit                 dup;
        if (b != term_byte) begin
            if (line_chars >= DEF_LINE_LIMIT)
                restart_line();
            if (b == 8'h00 && !zero_hit) begin
                zero_hit = 1'b1;
                zero_pos = line_chars;
            end
            if (line_chars < DEF_CODE_DIGITS) begin
                if (b >= ASCII_ZERO && b <= ASCII_NINE)
                    code_acc = code_acc * 10 + (b - ASCII_ZERO);
                else
                    all_digits = 1'b0;
            end
            line_chars++;
            return;
        end
        span    = zero_hit ? zero_pos : line_chars;
        code    = code_acc[VALUE_W-1:0];
        v.value = '0;
        v.slot  = '0;
        if (span != DEF_CODE_DIGITS) begin
            v.status = RES_LENGTH;
        end else if (!all_digits) begin
            v.status = RES_DIGIT;
        end else begin
            dup = 1'b0;
            foreach (seen_codes[i])
                if (seen_codes[i] == code)
                    dup = 1'b1;
            v.value = code;
            if (dup) begin
                v.status = RES_DUP;
            end else begin
                seen_codes[ring_ptr] = code;
                v.status = RES_ACCEPT;
                v.slot   = ring_ptr[SLOT_W-1:0];
                ring_ptr = (ring_ptr + 1 >= DEF_HISTORY_DEPTH) ? 0 : ring_ptr + 1;
            end
        end
        verdict_q.push_back(v);
        restart_line();
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        scan_byte_q.push_back(b);
        bytes_planned++;
    endfunction

    // Content bytes are kept off the terminator so the line shape holds.
    function automatic logic [BYTE_W-1:0] clear_of_term(input logic [BYTE_W-1:0] b);
        return (b == term_byte) ? b + 8'd1 : b;
    endfunction

    function automatic void push_code(input int unsigned value);
        int unsigned div;
        div = 100000;
        for (int i = 0; i < DEF_CODE_DIGITS; i++) begin
            push_byte(clear_of_term(BYTE_W'(ASCII_ZERO + (value / div) % 10)));
            div = div / 10;
        end
    endfunction

    function automatic void push_line(input string text);
        foreach (text[i])
            push_byte(text[i]);
        push_byte(term_byte);
    endfunction

    function automatic void queue_random_line();
        int          kind;
        int          n;
        int unsigned value;
        logic [BYTE_W-1:0] b;
        kind  = $urandom_range(99);
        value = ($urandom_range(99) < 60) ? code_pool[$urandom_range(POOL_SIZE - 1)]
                                          : $urandom_range(999999);
        if (kind < 55) begin
            push_code(value);
        end else if (kind < 65) begin
            n = $urandom_range(12);
            if (n == DEF_CODE_DIGITS)
                n = 0;
            repeat (n)
                push_byte(clear_of_term(BYTE_W'(ASCII_ZERO + $urandom_range(9))));
        end else if (kind < 75) begin
            // Six characters with one of them off the digit range.
            n = $urandom_range(DEF_CODE_DIGITS - 1);
            for (int i = 0; i < DEF_CODE_DIGITS; i++) begin
                if (i == n) begin
                    do b = BYTE_W'($urandom_range(255));
                    while ((b >= ASCII_ZERO && b <= ASCII_NINE) || b == term_byte);
                    push_byte(b);
                end else begin
                    push_byte(clear_of_term(BYTE_W'(ASCII_ZERO + $urandom_range(9))));
                end
            end
        end else if (kind < 82) begin
            // A zero byte cuts the length wherever it first lands.
            push_code(value);
            push_byte(clear_of_term(8'h00));
            repeat ($urandom_range(4))
                push_byte(clear_of_term(BYTE_W'($urandom_range(255))));
        end else if (kind < 90) begin
            // Overlong line: the tail after the wrap holds a code.
            repeat (DEF_LINE_LIMIT + $urandom_range(10))
                push_byte(clear_of_term(BYTE_W'($urandom_range(255))));
            push_code(value);
        end else begin
            repeat ($urandom_range(1, 45))
                push_byte(BYTE_W'($urandom_range(255)));
        end
        push_byte(term_byte);
    endfunction

    task automatic wait_drained();
        do @(negedge aclk);
        while (scan_byte_q.size() != 0 || s_valid || verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_terminator(input logic [BYTE_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        term_byte = value;
    endtask

    // Byte driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (scan_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid   <= 1'b1;
                s_rx_byte <= scan_byte_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            take_scan_byte(s_rx_byte);
    end

    // Verdict monitor.
    always @(posedge aclk) begin
        line_verdict_t exp_v;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected verdict beat: code %0d status %0d slot %0d",
                           m_code_value, m_status, m_slot_written);
                    mismatch_count++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    status_seen[exp_v.status]++;
                    if (m_code_value !== exp_v.value) begin
                        $error("code_value: expected %0d, actual %0d",
                               exp_v.value, m_code_value);
                        mismatch_count++;
                    end
                    if (m_status !== exp_v.status) begin
                        $error("status: expected %0d, actual %0d", exp_v.status, m_status);
                        mismatch_count++;
                    end
                    if (m_slot_written !== exp_v.slot) begin
                        $error("slot_written: expected %0d, actual %0d",
                               exp_v.slot, m_slot_written);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] phase_term [6];
        foreach (seen_codes[i])
            seen_codes[i] = '0;
        ring_ptr  = 0;
        term_byte = TERM_RESET;
        restart_line();
        code_pool[0] = 0;
        code_pool[1] = 999999;
        for (int i = 2; i < POOL_SIZE; i++)
            code_pool[i] = $urandom_range(999999);
        phase_term[0] = 8'd0;
        phase_term[1] = 8'd255;
        phase_term[2] = 8'd10;
        phase_term[3] = TERM_RESET;
        phase_term[4] = ASCII_ZERO + 8'd5;
        phase_term[5] = BYTE_W'($urandom_range(255));
        send_idle_pct = 14;
        recv_idle_pct = 85;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines under the reset terminator: empty line, the all-zero
        // code hitting the cleared history, the largest code, a line with
        // characters just outside the digit range, and a code cut short by a
        // zero byte right after its sixth digit.
        @(negedge aclk);
        push_byte(term_byte);
        push_line("000000");
        push_line("999999");
        push_byte(8'h2F);
        push_byte(8'h3A);
        push_byte(8'hFF);
        push_line("999");
        push_code(999998);
        push_byte(8'h00);
        push_line("x");
        wait_drained();

        foreach (phase_term[p]) begin
            if (p == 2) begin
                send_idle_pct = 85;
                recv_idle_pct = 14;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_terminator(phase_term[p]);
            @(negedge aclk);
            bytes_planned = 0;
            while (bytes_planned < PHASE_BYTES)
                queue_random_line();
            wait_drained();
        end

        $display("lines judged: %0d accepted, %0d wrong length, %0d bad digit, %0d duplicate",
                 status_seen[RES_ACCEPT], status_seen[RES_LENGTH],
                 status_seen[RES_DIGIT], status_seen[RES_DUP]);
        $display("six terminator settings, idle gaps on each channel, %0d cycles",
                 cycle_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== scan_code_dedupe_filter.f =====
src/scdf_pkg.sv
src/scdf_datapath.sv
src/scdf_ctrl.sv
src/scan_code_dedupe_filter.sv
dv/scan_code_dedupe_filter_tb.sv
